/* sv/rfd_pkg.sv */
// Shared types and constants for the fingerprint distance unit.
`timescale 1ns / 1ps
package rfd_pkg;
	localparam int unsigned TableDepth = 64;
	localparam int unsigned IdxW = $clog2(TableDepth);
	localparam int unsigned CntW = $clog2(TableDepth + 1);
	localparam logic signed [11:0] AbsentReset = -12'sd1600;
	localparam logic [47:0] SumMax = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_LOAD = 2'd1,
		ACT_MEASURE = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_ZERO_SPREAD = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_SCORE_MODE = 2'd0,
		CFG_ABSENT_LEVEL = 2'd1
	} cfg_idx_t;

	// Work item passed from front to back.
	typedef struct packed {
		action_t act;
		logic [47:0] ap_id;
		logic signed [11:0] level;
		logic [11:0] spread;
		logic scan_end;
	} item_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SEARCH,
		BK_SQUARE,
		BK_DIVIDE,
		BK_ACCUM,
		BK_OUT
	} bk_state_t;
endpackage

/* sv/rfd_front.sv */
// Front end: input queue of two items feeding the back end.
`timescale 1ns / 1ps
module rfd_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input rfd_pkg::item_t in_item,
	output logic item_valid,
	output rfd_pkg::item_t item,
	input logic item_take
);
	rfd_pkg::item_t buf_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic do_push, do_pop;

	assign full = cnt_q == 2'd2;
	assign item_valid = cnt_q != 2'd0;
	assign item = buf_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = item_take && item_valid;

	// Payload storage
	always_ff @(posedge clk) begin
		if (do_push) buf_q[wr_q] <= in_item;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("front queue overfilled");
	assert property (@(posedge clk) disable iff (!arst_n)
		full |-> item_valid) else $error("full while empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> item_valid) else $error("push lost");
endmodule

/* sv/rfd_back.sv */
// Back end: table search, square, restoring divide, saturating sum, result queue.
`timescale 1ns / 1ps
module rfd_back (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input rfd_pkg::item_t item,
	output logic item_take,
	input logic score_mode,
	input logic signed [11:0] absent_level,
	output logic empty,
	input logic pop,
	output logic [47:0] total,
	output logic [1:0] status,
	output logic final_res
);
	rfd_pkg::bk_state_t state_q, state_d;
	rfd_pkg::item_t cur_q;
	logic [47:0] key_mem [rfd_pkg::TableDepth];
	logic signed [11:0] lvl_mem [rfd_pkg::TableDepth];
	logic [rfd_pkg::TableDepth-1:0] valid_q;
	logic [rfd_pkg::CntW-1:0] count_q;
	logic [rfd_pkg::CntW-1:0] idx_q;
	logic [47:0] rd_key_q;
	logic signed [11:0] rd_lvl_q;
	logic rd_ok_q;
	logic signed [11:0] ref_q;
	logic found_q;
	logic [23:0] sq_q;
	logic [23:0] den_q;
	logic [39:0] quo_q;
	logic [24:0] rem_q;
	logic [5:0] bit_q;
	logic [47:0] sum_q;
	logic [47:0] out_total_q;
	logic [1:0] out_status_q;
	logic out_fin_q;
	logic out_full_q;
	logic [1:0] st_q;
	logic signed [12:0] diff;
	logic [12:0] mag;
	logic [48:0] add_res;
	logic [47:0] term;
	logic [24:0] rem_sh;
	logic launch, can_out;

	assign can_out = !out_full_q || pop;
	assign launch = state_q == rfd_pkg::BK_IDLE && item_valid;
	assign empty = !out_full_q;
	assign total = out_total_q;
	assign status = out_status_q;
	assign final_res = out_fin_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rfd_pkg::BK_IDLE: begin
				if (item_valid) begin
					if (item.act == rfd_pkg::ACT_MEASURE) state_d = rfd_pkg::BK_SEARCH;
					else state_d = rfd_pkg::BK_OUT;
				end
			end
			rfd_pkg::BK_SEARCH: begin
				if (found_q || (rd_ok_q && rd_key_q == cur_q.ap_id && valid_q != '0 &&
						idx_q != '0 && valid_q[idx_q[rfd_pkg::IdxW-1:0] - 1'b1]) ||
						idx_q > count_q)
					state_d = rfd_pkg::BK_SQUARE;
			end
			rfd_pkg::BK_SQUARE: begin
				if (!score_mode || cur_q.spread == '0) state_d = rfd_pkg::BK_ACCUM;
				else state_d = rfd_pkg::BK_DIVIDE;
			end
			rfd_pkg::BK_DIVIDE: if (bit_q == 6'd1) state_d = rfd_pkg::BK_ACCUM;
			rfd_pkg::BK_ACCUM: state_d = rfd_pkg::BK_OUT;
			rfd_pkg::BK_OUT: if (can_out) state_d = rfd_pkg::BK_IDLE;
			default: state_d = rfd_pkg::BK_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		item_take = 1'b0;
		unique case (state_q)
			rfd_pkg::BK_IDLE: item_take = item_valid;
			default: item_take = 1'b0;
		endcase
	end

	assign diff = {ref_q[11], ref_q} - {cur_q.level[11], cur_q.level};
	assign mag = diff[12] ? 13'(-diff) : diff;
	assign rem_sh = {rem_q[23:0], (bit_q > 6'd16) ? sq_q[5'(bit_q - 6'd17)] : 1'b0};
	assign term = (score_mode && cur_q.spread != '0) ? {8'd0, quo_q} : {24'd0, sq_q};
	assign add_res = {1'b0, sum_q} + {1'b0, term};

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (launch && item.act == rfd_pkg::ACT_LOAD && count_q < rfd_pkg::CntW'(rfd_pkg::TableDepth)) begin
			key_mem[count_q[rfd_pkg::IdxW-1:0]] <= item.ap_id;
			lvl_mem[count_q[rfd_pkg::IdxW-1:0]] <= item.level;
		end
		rd_key_q <= key_mem[idx_q[rfd_pkg::IdxW-1:0]];
		rd_lvl_q <= lvl_mem[idx_q[rfd_pkg::IdxW-1:0]];
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (launch) cur_q <= item;
		if (state_q == rfd_pkg::BK_SQUARE) begin
			sq_q <= 24'(mag * mag);
			den_q <= 24'(cur_q.spread * cur_q.spread);
			rem_q <= '0;
			quo_q <= '0;
			bit_q <= 6'd40;
		end else if (state_q == rfd_pkg::BK_DIVIDE) begin
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= rem_sh - {1'b0, den_q};
				quo_q <= {quo_q[38:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[38:0], 1'b0};
			end
			bit_q <= bit_q - 6'd1;
		end
	end

	// Search progress: the address leads the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			rd_ok_q <= 1'b0;
			found_q <= 1'b0;
			ref_q <= rfd_pkg::AbsentReset;
		end else if (launch) begin
			idx_q <= '0;
			rd_ok_q <= 1'b0;
			found_q <= 1'b0;
			ref_q <= absent_level;
		end else if (state_q == rfd_pkg::BK_SEARCH && !found_q) begin
			rd_ok_q <= idx_q < count_q;
			idx_q <= idx_q + 1'b1;
			if (rd_ok_q && rd_key_q == cur_q.ap_id) begin
				found_q <= 1'b1;
				ref_q <= rd_lvl_q;
			end
		end
	end

	// Control state, table bookkeeping and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rfd_pkg::BK_IDLE;
			valid_q <= '0;
			count_q <= '0;
			sum_q <= '0;
			st_q <= rfd_pkg::ST_OK;
			out_full_q <= 1'b0;
			out_total_q <= '0;
			out_status_q <= '0;
			out_fin_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (launch) begin
				st_q <= rfd_pkg::ST_OK;
				unique case (item.act)
					rfd_pkg::ACT_CLEAR: begin
						valid_q <= '0;
						count_q <= '0;
						sum_q <= '0;
					end
					rfd_pkg::ACT_LOAD: begin
						if (count_q < rfd_pkg::CntW'(rfd_pkg::TableDepth)) begin
							valid_q[count_q[rfd_pkg::IdxW-1:0]] <= 1'b1;
							count_q <= count_q + 1'b1;
						end else st_q <= rfd_pkg::ST_FULL;
					end
					default: ;
				endcase
			end
			if (state_q == rfd_pkg::BK_ACCUM) begin
				if (score_mode && cur_q.spread == '0) begin
					sum_q <= rfd_pkg::SumMax;
					st_q <= rfd_pkg::ST_ZERO_SPREAD;
				end else sum_q <= add_res[48] ? rfd_pkg::SumMax : add_res[47:0];
			end
			if (pop && out_full_q) out_full_q <= 1'b0;
			if (state_q == rfd_pkg::BK_OUT && can_out) begin
				out_full_q <= 1'b1;
				out_total_q <= sum_q;
				out_status_q <= st_q;
				out_fin_q <= cur_q.act == rfd_pkg::ACT_MEASURE && cur_q.scan_end;
				if (cur_q.act == rfd_pkg::ACT_MEASURE && cur_q.scan_end) sum_q <= '0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rfd_pkg::CntW'(rfd_pkg::TableDepth)) else $error("table count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(count_q)) else $error("valid bits disagree with count");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_full_q && !pop) |=> $stable(out_total_q)) else $error("result changed while held");
	assert property (@(posedge clk) disable iff (!arst_n)
		item_take |-> state_q == rfd_pkg::BK_IDLE) else $error("take while busy");
endmodule

/* sv/rssi_fingerprint_distance_unit.sv */
// Top level of the fingerprint distance unit.
// Usage: items enter through push/full as a queue; one result per item leaves
// through empty/pop, oldest first, with total, status and final_res on ports.
// Action clear empties the table and sum; load appends an entry; measure
// looks its id up (first match wins, absent_level otherwise) and adds the
// squared difference, or in z-score mode the Q.16 quotient, to the sum.
// scan_end on a measure reports the finished total and zeroes the sum.
// Flow from acceptance to result: clear, load and unused actions go from idle
// straight to the output state; a measure scans the table, then squares,
// runs the restoring divider in z-score mode when spread is nonzero,
// accumulates and registers the result.
// One item is processed at a time; the two-entry input queue takes the
// next items meanwhile. The result register holds its value while pop is
// low and the back end then waits.
// Configuration (cfg_valid/cfg_ready, always ready) must be written only
// while idle; the block does not enforce this. Reset empties table, sum and
// both queues and sets score_mode 0, absent_level -1600.
`timescale 1ns / 1ps
module rssi_fingerprint_distance_unit (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [1:0] action,
	input logic [47:0] ap_id,
	input logic signed [11:0] level,
	input logic [11:0] spread,
	input logic scan_end,
	output logic empty,
	input logic pop,
	output logic [47:0] total,
	output logic [1:0] status,
	output logic final_res,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [11:0] cfg_data
);
	rfd_pkg::item_t in_item, item;
	logic item_valid, item_take;
	logic score_mode_q;
	logic signed [11:0] absent_q;

	assign in_item = '{act: rfd_pkg::action_t'(action), ap_id: ap_id, level: level,
		spread: spread, scan_end: scan_end};
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_mode_q <= 1'b0;
			absent_q <= rfd_pkg::AbsentReset;
		end else if (cfg_valid) begin
			unique case (rfd_pkg::cfg_idx_t'(cfg_index))
				rfd_pkg::CFG_SCORE_MODE: score_mode_q <= cfg_data[0];
				rfd_pkg::CFG_ABSENT_LEVEL: absent_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rfd_front u_front (.clk, .arst_n, .push, .full, .in_item, .item_valid, .item,
		.item_take);

	rfd_back u_back (.clk, .arst_n, .item_valid, .item, .item_take,
		.score_mode(score_mode_q), .absent_level(absent_q), .empty, .pop, .total,
		.status, .final_res);
endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the fingerprint distance unit.
`timescale 1ns / 1ps
module tb_top;
	localparam int RowCount = 22;
	localparam int RandCount = 650;
	localparam int IdleLimit = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [1:0] action = rfd_pkg::ACT_CLEAR;
	logic [47:0] ap_id = '0;
	logic signed [11:0] level = '0;
	logic [11:0] spread = '0;
	logic scan_end = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [47:0] total;
	logic [1:0] status;
	logic final_res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = rfd_pkg::CFG_SCORE_MODE;
	logic [11:0] cfg_data = '0;

	rssi_fingerprint_distance_unit dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	typedef struct packed {
		logic [47:0] total;
		logic [1:0] status;
		logic final_res;
	} dist_res_t;

	// Shadow copy of the block state
	logic model_zmode;
	logic signed [11:0] model_absent;
	logic [47:0] model_keys [rfd_pkg::TableDepth];
	logic signed [11:0] model_levels [rfd_pkg::TableDepth];
	int model_count;
	logic [47:0] model_sum;

	dist_res_t pending_q [$];
	int errors = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;
	bit rx_on = 1'b1;
	int zspread_hits = 0;
	int full_hits = 0;

	// Keys kept for random measure hits
	logic [47:0] known_keys [$];

	function automatic logic [47:0] sum_sat(input logic [47:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {17'd0, a} + {1'b0, b};
		return (s > {17'd0, rfd_pkg::SumMax}) ? rfd_pkg::SumMax : s[47:0];
	endfunction

	// Distance accumulator prediction for one transaction
	function automatic dist_res_t predict_distance(input rfd_pkg::action_t act,
		input logic [47:0] key, input logic signed [11:0] lvl, input logic [11:0] spr,
		input logic last);
		dist_res_t r;
		logic signed [12:0] ref_lvl;
		logic signed [13:0] d;
		logic [63:0] sq;
		bit hit;
		r.status = rfd_pkg::ST_OK;
		r.final_res = 1'b0;
		hit = 1'b0;
		case (act)
			rfd_pkg::ACT_CLEAR: begin
				model_count = 0;
				model_sum = '0;
			end
			rfd_pkg::ACT_LOAD: begin
				if (model_count < rfd_pkg::TableDepth) begin
					model_keys[model_count] = key;
					model_levels[model_count] = lvl;
					model_count++;
				end else begin
					r.status = rfd_pkg::ST_FULL;
				end
			end
			rfd_pkg::ACT_MEASURE: begin
				ref_lvl = 13'(model_absent);
				for (int i = 0; i < model_count; i++) begin
					if (!hit && model_keys[i] == key) begin
						ref_lvl = 13'(model_levels[i]);
						hit = 1'b1;
					end
				end
				d = 14'(ref_lvl) - 14'(lvl);
				if (d < 0) d = -d;
				sq = 64'(d) * 64'(d);
				if (!model_zmode) model_sum = sum_sat(model_sum, sq);
				else if (spr == 0) begin
					model_sum = rfd_pkg::SumMax;
					r.status = rfd_pkg::ST_ZERO_SPREAD;
				end else model_sum = sum_sat(model_sum, (sq << 16) / (64'(spr) * 64'(spr)));
			end
			default: ;
		endcase
		r.total = model_sum;
		if (act == rfd_pkg::ACT_MEASURE && last) begin
			r.final_res = 1'b1;
			model_sum = '0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [47:0] got,
		input logic [47:0] want);
		errors++;
		$display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
	endtask

	// Result side: check each popped transaction
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			dist_res_t e;
			results_seen++;
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected result", total, 48'd0);
			end else begin
				e = pending_q.pop_front();
				if (total !== e.total) report_mismatch("total", total, e.total);
				if (status !== e.status)
					report_mismatch("status", 48'(status), 48'(e.status));
				if (final_res !== e.final_res)
					report_mismatch("final_res", 48'(final_res), 48'(e.final_res));
			end
		end
	end

	// Receiver stalls in random bursts
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (no_idle || !rx_on) pop <= rx_on;
			else if ($urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 13);
				pop <= 1'b0;
				repeat (n) @(posedge clk);
				pop <= 1'b1;
			end else pop <= 1'b1;
		end
	end

	// Watchdog on accepted transactions
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || cfg_valid) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("rssi_fingerprint_distance_unit verification failed");
			$finish;
		end
	end

	task automatic send_item(input rfd_pkg::action_t act, input logic [47:0] key,
		input logic signed [11:0] lvl, input logic [11:0] spr, input logic last,
		input bit has_want, input dist_res_t want);
		dist_res_t e;
		if (!no_idle && $urandom_range(0, 6) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		push <= 1'b1;
		action <= act;
		ap_id <= key;
		level <= lvl;
		spread <= spr;
		scan_end <= last;
		@(posedge clk);
		while (full) @(posedge clk);
		e = predict_distance(act, key, lvl, spr, last);
		if (act == rfd_pkg::ACT_LOAD && e.status == rfd_pkg::ST_FULL) full_hits++;
		if (e.status == rfd_pkg::ST_ZERO_SPREAD) zspread_hits++;
		if (has_want && e != want) report_mismatch("directed row", e.total, want.total);
		pending_q.push_back(has_want ? want : e);
	endtask

	// Drain, let the block settle, then write one register
	task automatic write_reg(input rfd_pkg::cfg_idx_t idx, input logic [11:0] val);
		push <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == rfd_pkg::CFG_SCORE_MODE) model_zmode = val[0];
		else model_absent = val;
	endtask

	typedef struct {
		rfd_pkg::action_t act;
		logic [47:0] key;
		logic signed [11:0] lvl;
		logic [11:0] spr;
		logic last;
		bit has_want;
		dist_res_t want;
	} stim_row_t;

	stim_row_t dir_rows [RowCount] = '{
		'{rfd_pkg::ACT_CLEAR, 48'd0, 12'sd0, 12'd0, 1'b1, 1'b1,
			'{48'd0, rfd_pkg::ST_OK, 1'b0}},
		// absent id at reset absent level: d = -1600 - 0
		'{rfd_pkg::ACT_MEASURE, 48'hFFFF_FFFF_FFFF, 12'sd0, 12'd0, 1'b1, 1'b1,
			'{48'd2560000, rfd_pkg::ST_OK, 1'b1}},
		'{rfd_pkg::ACT_NONE, 48'h1234, 12'sd5, 12'd7, 1'b1, 1'b1,
			'{48'd0, rfd_pkg::ST_OK, 1'b0}},
		'{rfd_pkg::ACT_LOAD, 48'h0, -12'sd2048, 12'd0, 1'b1, 1'b1,
			'{48'd0, rfd_pkg::ST_OK, 1'b0}},
		'{rfd_pkg::ACT_LOAD, 48'hFFFF_FFFF_FFFF, 12'sd2047, 12'hFFF, 1'b0, 1'b1,
			'{48'd0, rfd_pkg::ST_OK, 1'b0}},
		'{rfd_pkg::ACT_LOAD, 48'h0, 12'sd100, 12'd0, 1'b0, 1'b1,
			'{48'd0, rfd_pkg::ST_OK, 1'b0}},
		// first match wins on duplicate key
		'{rfd_pkg::ACT_MEASURE, 48'h0, 12'sd2047, 12'd0, 1'b0, 1'b1,
			'{48'd16769025, rfd_pkg::ST_OK, 1'b0}},
		'{rfd_pkg::ACT_MEASURE, 48'hFFFF_FFFF_FFFF, -12'sd2048, 12'd1, 1'b1, 1'b1,
			'{48'd33538050, rfd_pkg::ST_OK, 1'b1}},
		'{rfd_pkg::ACT_MEASURE, 48'hAAAA_5555_AAAA, -12'sd1600, 12'd0, 1'b1, 1'b1,
			'{48'd0, rfd_pkg::ST_OK, 1'b1}},
		'{rfd_pkg::ACT_MEASURE, 48'h5555_AAAA_5555, 12'sd2047, 12'hFFF, 1'b0, 1'b0,
			'{48'd0, rfd_pkg::ST_OK, 1'b0}},
		'{rfd_pkg::ACT_NONE, 48'h0, 12'sd0, 12'd0, 1'b0, 1'b0,
			'{48'd0, rfd_pkg::ST_OK, 1'b0}},
		'{rfd_pkg::ACT_MEASURE, 48'h0, -12'sd2048, 12'd0, 1'b1, 1'b0,
			'{48'd0, rfd_pkg::ST_OK, 1'b0}},
		'{rfd_pkg::ACT_CLEAR, 48'h0, 12'sd0, 12'd0, 1'b0, 1'b1,
			'{48'd0, rfd_pkg::ST_OK, 1'b0}},
		'{rfd_pkg::ACT_MEASURE, 48'h0, 12'sd0, 12'd0, 1'b1, 1'b1,
			'{48'd2560000, rfd_pkg::ST_OK, 1'b1}},
		'{rfd_pkg::ACT_LOAD, 48'h1, 12'sd0, 12'd0, 1'b0, 1'b0,
			'{48'd0, rfd_pkg::ST_OK, 1'b0}},
		'{rfd_pkg::ACT_LOAD, 48'h2, -12'sd1, 12'd0, 1'b0, 1'b0,
			'{48'd0, rfd_pkg::ST_OK, 1'b0}},
		'{rfd_pkg::ACT_MEASURE, 48'h2, 12'sd1, 12'd0, 1'b0, 1'b0,
			'{48'd0, rfd_pkg::ST_OK, 1'b0}},
		'{rfd_pkg::ACT_MEASURE, 48'h1, 12'sd3, 12'd0, 1'b1, 1'b0,
			'{48'd0, rfd_pkg::ST_OK, 1'b0}},
		'{rfd_pkg::ACT_MEASURE, 48'h3, 12'sd0, 12'd0, 1'b0, 1'b0,
			'{48'd0, rfd_pkg::ST_OK, 1'b0}},
		'{rfd_pkg::ACT_LOAD, 48'h3, 12'sd0, 12'd0, 1'b1, 1'b0,
			'{48'd0, rfd_pkg::ST_OK, 1'b0}},
		'{rfd_pkg::ACT_MEASURE, 48'h3, 12'sd0, 12'd0, 1'b1, 1'b0,
			'{48'd0, rfd_pkg::ST_OK, 1'b0}},
		'{rfd_pkg::ACT_CLEAR, 48'h0, 12'sd0, 12'd0, 1'b1, 1'b0,
			'{48'd0, rfd_pkg::ST_OK, 1'b0}}
	};

	// Random key: often from the table, sometimes fresh
	function automatic logic [47:0] pick_key();
		if (known_keys.size() != 0 && $urandom_range(0, 3) != 0)
			return known_keys[$urandom_range(0, known_keys.size() - 1)];
		return 48'({$urandom_range(0, 65535), $urandom()});
	endfunction

	function automatic logic [11:0] pick_spread();
		case ($urandom_range(0, 9))
			0: return 12'd0;
			1: return 12'hFFF;
			2, 3: return 12'($urandom_range(1, 15));
			default: return 12'($urandom());
		endcase
	endfunction

	initial begin
		dist_res_t none;
		int phase, sent, n;
		logic [47:0] k;
		none = '{48'd0, rfd_pkg::ST_OK, 1'b0};
		model_zmode = 1'b0;
		model_absent = rfd_pkg::AbsentReset;
		model_count = 0;
		model_sum = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].act, dir_rows[i].key, dir_rows[i].lvl, dir_rows[i].spr,
				dir_rows[i].last, dir_rows[i].has_want, dir_rows[i].want);

		// Random scans over several register settings
		sent = 0;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_reg(rfd_pkg::CFG_SCORE_MODE, 12'd1);
					write_reg(rfd_pkg::CFG_ABSENT_LEVEL, 12'h800);
				end
				1: write_reg(rfd_pkg::CFG_ABSENT_LEVEL, 12'h000);
				2: write_reg(rfd_pkg::CFG_SCORE_MODE, 12'd0);
				3: begin
					write_reg(rfd_pkg::CFG_SCORE_MODE, 12'd1);
					write_reg(rfd_pkg::CFG_ABSENT_LEVEL, 12'hE7F);
				end
				4: begin
					write_reg(rfd_pkg::CFG_SCORE_MODE, 12'd0);
					write_reg(rfd_pkg::CFG_ABSENT_LEVEL, 12'($urandom_range(0, 2048) * -1));
				end
				default: begin
					write_reg(rfd_pkg::CFG_SCORE_MODE, 12'd1);
					rx_on = 1'b1;
					no_idle = 1'b1;
				end
			endcase
			// New table, sized to overflow in phase 2
			send_item(rfd_pkg::ACT_CLEAR, 48'({$urandom(), $urandom()}), 12'($urandom()),
				12'($urandom()), 1'($urandom()), 1'b0, none);
			known_keys.delete();
			n = (phase == 2) ? int'(rfd_pkg::TableDepth) + 3 : $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				k = pick_key();
				known_keys.push_back(k);
				send_item(rfd_pkg::ACT_LOAD, k, 12'($urandom()), 12'($urandom()),
					1'($urandom()), 1'b0, none);
			end
			sent += n + 1;
			while (sent < RandCount * (phase + 1) / 6) begin
				case ($urandom_range(0, 19))
					0: send_item(rfd_pkg::ACT_NONE, pick_key(), 12'($urandom()),
						12'($urandom()), 1'($urandom()), 1'b0, none);
					1: begin
						k = pick_key();
						known_keys.push_back(k);
						send_item(rfd_pkg::ACT_LOAD, k, 12'($urandom()), 12'($urandom()),
							1'($urandom()), 1'b0, none);
					end
					default: send_item(rfd_pkg::ACT_MEASURE, pick_key(), 12'($urandom()),
						pick_spread(), $urandom_range(0, 4) == 0, 1'b0, none);
				endcase
				sent++;
			end
		end

		push <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Covered %0d results over plain and z-score modes and absent levels", results_seen);
		$display("Table overflows %0d, zero spread hits %0d", full_hits, zspread_hits);
		if (errors == 0) $display("rssi_fingerprint_distance_unit verification clean");
		else $display("rssi_fingerprint_distance_unit verification failed");
		$finish;
	end
endmodule

/* files.f */
sv/rfd_pkg.sv
sv/rfd_front.sv
sv/rfd_back.sv
sv/rssi_fingerprint_distance_unit.sv
verif/tb_top.sv
